/* hw/rtl/bpfm_pkg.sv */
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared constants and types for the byte pattern first-match search block.
// ----------------------------------------------------------------------------
package bpfm_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = PAT_BYTES * 8;
    localparam int PAT_SEL_W = $clog2(PAT_BYTES);
    localparam int LEN_W     = 5;
    localparam int OFF_W     = 32;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_START    = 2'd3;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } t_result;

endpackage

/* hw/rtl/bpfm_cell.sv */
// ----------------------------------------------------------------------------
// bpfm_cell
// One window cell: holds one buffer byte, passes it on to the next cell on
// every transfer, and compares the incoming byte with its pattern byte.
// ----------------------------------------------------------------------------
module bpfm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [7:0]                 i_byte,
    input  logic [bpfm_pkg::PAT_W-1:0] i_pattern,
    input  logic [bpfm_pkg::LEN_W-1:0] i_length,
    output logic [7:0]                 o_byte,
    output logic                       o_hit
);
    import bpfm_pkg::*;

    logic [7:0]           r_byte;
    logic [7:0]           diff;
    logic [PAT_SEL_W-1:0] sel;
    logic [7:0]           pat_byte;
    logic                 unused;

    // cell k checks pattern byte (length - 1 - k); cells past the length pass
    assign diff     = {3'b000, i_length} - 8'(CELL_IDX) - 8'd1;
    assign sel      = diff[PAT_SEL_W-1:0];
    assign pat_byte = i_pattern[sel*8 +: 8];
    assign unused   = 8'(CELL_IDX) >= {3'b000, i_length};
    assign o_hit    = unused || (i_byte == pat_byte);
    assign o_byte   = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= i_byte;
        end
    end

endmodule

/* hw/rtl/byte_pattern_first_match.sv */
// ----------------------------------------------------------------------------
// byte_pattern_first_match
// Streaming first-match search of a 1 to 16 byte pattern in a byte buffer.
// Results are registered in the output register, or in the skid entry.
// Throughput: one byte per cycle unless stalled; the cell chain compares all
// window positions at once and a two-entry output buffer decouples the sides.
// Reset: synchronous, active low; clears counter, flags, output buffer and
// sets pattern_length to 1. The window bytes are not cleared.
// ----------------------------------------------------------------------------
module byte_pattern_first_match #(
    parameter int MAX_PATTERN = bpfm_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = bpfm_pkg::OFFSET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_buffer,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [bpfm_pkg::OFF_W-1:0]  o_start_offset,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpfm_pkg::ADDR_W-1:0] paddr,
    input  logic [bpfm_pkg::DATA_W-1:0] pwdata,
    output logic [bpfm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import bpfm_pkg::*;

    localparam int CMP_W = (OFFSET_BITS > OFF_W) ? OFFSET_BITS : OFF_W;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic [DATA_W-1:0]      r_pat_low;
    logic [DATA_W-1:0]      r_pat_high;
    logic [LEN_W-1:0]       r_len;
    logic [OFF_W-1:0]       r_start;

    logic [OFFSET_BITS-1:0] r_seen;
    logic                   r_answered;

    logic                   r_out_valid;
    t_result                r_out;
    logic                   r_skid_valid;
    t_result                r_skid;

    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   accept;
    logic                   out_take;
    logic [PAT_W-1:0]       pattern;
    logic [7:0]             chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;
    logic                   rep;
    logic                   len_ok;
    logic [CMP_W-1:0]       pos1;
    logic [CMP_W-1:0]       len_ext;
    logic [CMP_W-1:0]       start_pos;
    logic                   match;
    logic                   res_valid;
    t_result                res;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            REG_PAT_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, r_len};
            REG_START:    prdata = {{(DATA_W-OFF_W){1'b0}}, r_start};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= LEN_RESET;
            r_start    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PAT_LOW:  r_pat_low  <= pwdata;
                REG_PAT_HIGH: r_pat_high <= pwdata;
                REG_PAT_LEN:  r_len      <= pwdata[LEN_W-1:0];
                REG_START:    r_start    <= pwdata[OFF_W-1:0];
                default:      ;
            endcase
        end
    end

    // window cell chain
    assign accept  = i_in_valid && !o_in_stall;
    assign pattern = {r_pat_high, r_pat_low};
    assign chain[0] = i_data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        bpfm_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_en      (accept),
            .i_byte    (chain[k]),
            .i_pattern (pattern),
            .i_length  (r_len),
            .o_byte    (chain[k+1]),
            .o_hit     (hits[k])
        );
    end

    // match decision
    assign rep       = r_seen != COUNT_MAX;
    assign len_ok    = (r_len != '0) && (r_len <= LEN_W'(PAT_BYTES))
                       && ({{(CMP_W-LEN_W){1'b0}}, r_len} <= CMP_W'(MAX_PATTERN));
    assign pos1      = CMP_W'(r_seen) + CMP_W'(1);
    assign len_ext   = {{(CMP_W-LEN_W){1'b0}}, r_len};
    assign start_pos = pos1 - len_ext;
    assign match     = rep && len_ok && (pos1 >= len_ext)
                       && (start_pos >= CMP_W'(r_start)) && (&hits);
    assign res_valid = accept && !r_answered && (match || i_end_of_buffer);
    assign res.found  = match;
    assign res.offset = match ? start_pos[OFF_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_answered <= 1'b0;
        end else if (accept) begin
            if (i_end_of_buffer) begin
                r_seen     <= '0;
                r_answered <= 1'b0;
            end else begin
                if (rep) begin
                    r_seen <= r_seen + OFFSET_BITS'(1);
                end
                if (match) begin
                    r_answered <= 1'b1;
                end
            end
        end
    end

    // output register plus skid entry
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || res_valid;
            r_skid_valid <= r_skid_valid && res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
            if (r_skid_valid && res_valid) begin
                r_skid <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out.found;
    assign o_start_offset = r_out.offset;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_buffer |=> (r_seen == '0) && !r_answered)
        else $error("buffer state not cleared after final byte");

    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !i_end_of_buffer |=> r_answered)
        else $error("match result given without marking buffer answered");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_skid_valid && !r_answered)
        else $error("control state not cleared by reset");
`endif

endmodule
